@@ src/mtfsl_pkg.sv @@
// Shared types and constants for the move-to-front search list.
package mtfsl_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int POS_W        = 4;
	localparam int COUNT_W      = 5;
	localparam int STATUS_W     = 2;

	// request kinds
	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_FIND   = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

	typedef enum logic [0:0] {
		S_IDLE,
		S_SCAN
	} state_t;

	typedef struct packed {
		logic                      req_type;
		logic signed [VALUE_W-1:0] item_value;
	} req_item_t;

	typedef struct packed {
		logic                hit;
		logic [POS_W-1:0]    hit_position;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  entry_count_now;
	} rsp_item_t;

	// commands broadcast from the controller to every cell
	typedef struct packed {
		logic                      cmp;
		logic                      append;
		logic                      move;
		logic signed [VALUE_W-1:0] key;
	} cell_ctl_t;

endpackage

@@ src/move_to_front_search_list_unit.sv @@
// Top level of the move-to-front search list: controller and a row of cells.
//
//  channel | valid     | ready     | payload             | transfer
//  --------+-----------+-----------+---------------------+-------------------------------
//  request | req_valid | req_ready | req (req_item_t)    | append or find one value
//  result  | rsp_valid | rsp_ready | rsp (rsp_item_t)    | one result per request
//
// An append, or a find on an empty list, gives its result the cycle after its transfer.
// A find compares all cells in the transfer cycle, then walks the match flags one cell
// a cycle from the front until a hit or the last entry, and its result is registered
// when the walk ends; a hit shifts the cells ahead of it in the same cycle.
// Reset clears the count but not the entries; entries at or beyond the count never match.
// A waiting result holds off a new transfer until the cycle it is taken, and a finished
// scan holds until the result register is free.
module move_to_front_search_list_unit #(
	parameter int CAPACITY = mtfsl_pkg::CAPACITY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  mtfsl_pkg::req_item_t req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output mtfsl_pkg::rsp_item_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	mtfsl_pkg::cell_ctl_t ctl;
	logic [CNT_W-1:0]     ptr;
	logic [CNT_W-1:0]     count;
	logic [CAPACITY-1:0]  match_vec;
	logic signed [mtfsl_pkg::VALUE_W-1:0] cell_value [CAPACITY];

	mtfsl_ctrl #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W),
		.IDX_W    (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.match_vec (match_vec),
		.ctl       (ctl),
		.ptr       (ptr),
		.count     (count)
	);

	// row of cells; the front cell takes the key on a move, the rest their left neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [mtfsl_pkg::VALUE_W-1:0] left_value;
		if (i == 0) begin : g_front
			assign left_value = ctl.key;
		end else begin : g_rest
			assign left_value = cell_value[i-1];
		end
		mtfsl_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.ptr        (ptr),
			.count      (count),
			.left_value (left_value),
			.value      (cell_value[i]),
			.match      (match_vec[i])
		);
	end

endmodule

@@ src/mtfsl_cell.sv @@
// One storage cell of the list: holds an entry, compares it, takes its neighbor's entry.
module mtfsl_cell #(
	parameter int CNT_W = mtfsl_pkg::COUNT_W,
	parameter int IDX   = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mtfsl_pkg::cell_ctl_t                ctl,
	input  logic [CNT_W-1:0]                    ptr,
	input  logic [CNT_W-1:0]                    count,
	input  logic signed [mtfsl_pkg::VALUE_W-1:0] left_value,
	output logic signed [mtfsl_pkg::VALUE_W-1:0] value,
	output logic                                match
);

	logic signed [mtfsl_pkg::VALUE_W-1:0] value_q;
	logic                                 match_q;
	logic                                 valid;
	logic                                 at_ptr;
	logic                                 ahead_of_ptr;

	assign valid        = count > CNT_W'(IDX);
	assign at_ptr       = ptr == CNT_W'(IDX);
	assign ahead_of_ptr = CNT_W'(IDX) <= ptr;

	// entry storage: append writes the tail, a move shifts from the left neighbor
	always_ff @(posedge clk) begin
		if (ctl.append && at_ptr) begin
			value_q <= ctl.key;
		end else if (ctl.move && ahead_of_ptr) begin
			value_q <= left_value;
		end
	end

	// compare result, captured once per find
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp) begin
			match_q <= valid && (value_q == ctl.key);
		end
	end

	assign value = value_q;
	assign match = match_q;

endmodule

@@ src/mtfsl_ctrl.sv @@
// Controller: handshakes, entry count, front-to-back scan of match flags, result register.
module mtfsl_ctrl #(
	parameter int CAPACITY = mtfsl_pkg::CAPACITY_DEF,
	parameter int CNT_W    = $clog2(CAPACITY + 1),
	parameter int IDX_W    = $clog2(CAPACITY)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  mtfsl_pkg::req_item_t  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output mtfsl_pkg::rsp_item_t  rsp,
	input  logic [CAPACITY-1:0]   match_vec,
	output mtfsl_pkg::cell_ctl_t  ctl,
	output logic [CNT_W-1:0]      ptr,
	output logic [CNT_W-1:0]      count
);

	mtfsl_pkg::state_t    state_q, state_d;
	logic [IDX_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic signed [mtfsl_pkg::VALUE_W-1:0] key_q;
	mtfsl_pkg::rsp_item_t rsp_q, res;
	logic                 rsp_valid_q;
	logic                 res_load;
	logic                 accept;
	logic                 out_free;
	logic                 cur_match;
	logic                 last;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == mtfsl_pkg::S_IDLE) && out_free;
	assign accept    = req_valid && req_ready;
	assign cur_match = match_vec[ptr_q];
	assign last      = (CNT_W'(ptr_q) + CNT_W'(1)) == count_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mtfsl_pkg::S_IDLE: begin
				if (accept && req.req_type == mtfsl_pkg::REQ_FIND && count_q != '0) begin
					state_d = mtfsl_pkg::S_SCAN;
				end
			end
			mtfsl_pkg::S_SCAN: begin
				if (out_free && (cur_match || last)) begin
					state_d = mtfsl_pkg::S_IDLE;
				end
			end
			default: state_d = mtfsl_pkg::S_IDLE;
		endcase
	end

	// cell commands and result
	always_comb begin
		ctl      = '0;
		ptr      = '0;
		res_load = 1'b0;
		res      = '0;
		res.entry_count_now = mtfsl_pkg::COUNT_W'(count_q);
		case (state_q)
			mtfsl_pkg::S_IDLE: begin
				if (accept) begin
					if (req.req_type == mtfsl_pkg::REQ_APPEND) begin
						res_load = 1'b1;
						if (count_q == CNT_W'(CAPACITY)) begin
							res.status = mtfsl_pkg::STAT_FULL;
						end else begin
							ctl.append = 1'b1;
							ctl.key    = req.item_value;
							ptr        = count_q;
							res.status = mtfsl_pkg::STAT_DONE;
							res.entry_count_now =
								mtfsl_pkg::COUNT_W'(count_q + CNT_W'(1));
						end
					end else if (count_q == '0) begin
						res_load   = 1'b1;
						res.status = mtfsl_pkg::STAT_NOT_FOUND;
					end else begin
						ctl.cmp = 1'b1;
						ctl.key = req.item_value;
					end
				end
			end
			mtfsl_pkg::S_SCAN: begin
				if (out_free) begin
					if (cur_match) begin
						ctl.move         = 1'b1;
						ctl.key          = key_q;
						ptr              = CNT_W'(ptr_q);
						res_load         = 1'b1;
						res.hit          = 1'b1;
						res.hit_position = mtfsl_pkg::POS_W'(ptr_q);
						res.status       = mtfsl_pkg::STAT_DONE;
					end else if (last) begin
						res_load   = 1'b1;
						res.status = mtfsl_pkg::STAT_NOT_FOUND;
					end
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtfsl_pkg::S_IDLE;
			ptr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.append) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (ctl.cmp) begin
				ptr_q <= '0;
			end else if (state_q == mtfsl_pkg::S_SCAN && !cur_match && !last) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
			if (res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			key_q <= ctl.key;
		end
		if (res_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign count     = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mtfsl_pkg::S_SCAN |-> CNT_W'(ptr_q) < count_q)
		else $error("scan pointer past the last valid entry");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.cmp, ctl.append, ctl.move}))
		else $error("more than one cell command at once");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.append |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("append did not grow the count");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result loaded over one not yet taken");

endmodule
